### rtl/rwc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwc_pkg
// shared types and constants for the rgb window convolution core
// ----------------------------------------------------------------------------
package rwc_pkg;

  localparam int CFG_W      = 60;   // widest configuration register
  localparam int CFG_IDX_W  = 3;
  localparam int DIM_W      = 12;   // image_width / image_height registers
  localparam int ROW_W      = 11;   // row counter
  localparam int MAX_HEIGHT = 2048;
  localparam int PIX_W      = 24;
  localparam int COEF_ROWS  = 5;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_ROW0    = 3'd0,
    REG_COEF_ROW1    = 3'd1,
    REG_COEF_ROW2    = 3'd2,
    REG_COEF_ROW3    = 3'd3,
    REG_COEF_ROW4    = 3'd4,
    REG_IMAGE_WIDTH  = 3'd5,
    REG_IMAGE_HEIGHT = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_last;
  } pixel_out_t;

endpackage

### rtl/rwc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwc_ram
// generic simple dual port ram, one write and one registered read port,
// read returns the old contents on a same-address write
// ----------------------------------------------------------------------------
module rwc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/rgb_window_convolution_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_window_convolution_core
// valid-region 2-d convolution of an rgb raster stream with one kernel
// shared by all three channels, truncated and clamped to 8 bits
// ----------------------------------------------------------------------------
// pipeline from input accept to out_valid: pixel register, window, products, row sums, then the output queue
// throughput: one pixel per clock while in_stall is low, set by the line store ports
//   and the fully pipelined multiply / add tree
// in_stall rises only when 8 results are pending (output queue plus pipeline)
// reset: synchronous, clears counters, window, queue and config to defaults;
//   line store contents are not cleared and need no clearing pass
// ----------------------------------------------------------------------------
module rgb_window_convolution_core #(
  parameter int KERNEL_SIZE = 5,
  parameter int MAX_WIDTH   = 2048,
  parameter int COEF_BITS   = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_write,
  input  logic [rwc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rwc_pkg::CFG_W-1:0]           cfg_data,
  // pixel input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rwc_pkg::pixel_in_t                  in_item,
  // filtered output
  output logic                                out_valid,
  input  logic                                out_stall,
  output rwc_pkg::pixel_out_t                 out_item
);

  import rwc_pkg::*;

  localparam int KS    = KERNEL_SIZE;
  localparam int SLOTS = (KS > 1) ? KS - 1 : 1;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PW    = COEF_BITS + 8;     // one coefficient times one sample
  localparam int RSW   = PW + 3;            // sum over one kernel row
  localparam int TSW   = RSW + 3;           // sum over the whole kernel
  localparam int QW    = TSW - COEF_BITS;   // sum after dropping the fraction

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] coef_row [COEF_ROWS];
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < COEF_ROWS; i++) begin
        coef_row[i] <= '0;
      end
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COEF_ROW0:    coef_row[0] <= cfg_data;
        REG_COEF_ROW1:    coef_row[1] <= cfg_data;
        REG_COEF_ROW2:    coef_row[2] <= cfg_data;
        REG_COEF_ROW3:    coef_row[3] <= cfg_data;
        REG_COEF_ROW4:    coef_row[4] <= cfg_data;
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[DIM_W-1:0];
        default: ;  // unused index, write is dropped
      endcase
    end
  end

  // effective geometry: zero reads as one, oversize saturates
  logic [CW:0]      width_eff;
  logic [DIM_W-1:0] height_eff;

  always_comb begin
    if (image_width == '0) begin
      width_eff = (CW+1)'(1);
    end else if ({1'b0, image_width} > (DIM_W+1)'(MAX_WIDTH)) begin
      width_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      width_eff = (CW+1)'(image_width);
    end
    if (image_height == '0) begin
      height_eff = DIM_W'(1);
    end else if (image_height > DIM_W'(MAX_HEIGHT)) begin
      height_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      height_eff = image_height;
    end
  end

  // --------------------------------------------------------------------------
  // handshake and result credit
  // pending counts results owed: items in the pipeline that will give one
  // plus entries in the output queue, so the queue can never overflow
  // --------------------------------------------------------------------------
  logic [FIFO_AW:0] pending;
  logic [FIFO_AW:0] pending_next;
  logic             in_acc;
  logic             out_acc;

  assign in_stall = (pending == (FIFO_AW+1)'(FIFO_DEPTH));
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;

  // --------------------------------------------------------------------------
  // raster position
  // --------------------------------------------------------------------------
  logic [CW-1:0]    col;
  logic [ROW_W-1:0] row;
  logic [SW-1:0]    slot;       // line store slot of the current row
  logic [CW:0]      col_inc;
  logic [DIM_W-1:0] row_inc;
  logic             col_wrap;
  logic             row_wrap;
  logic             emit_now;
  logic             last_now;
  logic [PIX_W-1:0] pix;

  assign col_inc  = {1'b0, col} + (CW+1)'(1);
  assign row_inc  = {1'b0, row} + DIM_W'(1);
  assign col_wrap = (col_inc >= width_eff);
  assign row_wrap = (row_inc >= height_eff);
  // a result only once the whole window lies inside the frame
  assign emit_now = (row >= ROW_W'(KS - 1)) && (col >= CW'(KS - 1));
  assign last_now = col_wrap && row_wrap;
  assign pix      = {in_item.blue_in, in_item.green_in, in_item.red_in};

  assign pending_next = pending + (FIFO_AW+1)'(in_acc && emit_now)
                      - (FIFO_AW+1)'(out_acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      row     <= '0;
      slot    <= '0;
      pending <= '0;
    end else begin
      pending <= pending_next;
      if (in_acc) begin
        if (col_wrap) begin
          col <= '0;
          if (row_wrap) begin
            row  <= '0;
            slot <= '0;
          end else begin
            row  <= row_inc[ROW_W-1:0];
            slot <= (slot == SW'(SLOTS - 1)) ? '0 : slot + SW'(1);
          end
        end else begin
          col <= col_inc[CW-1:0];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: line store read, pixel register
  // --------------------------------------------------------------------------
  logic             s1_valid;
  logic             s1_emit;
  logic             s1_last;
  logic [PIX_W-1:0] s1_pix;
  logic [PIX_W-1:0] colv [KS];   // new window column, top row first

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_acc;
    end
    if (in_acc) begin
      s1_pix  <= pix;
      s1_emit <= emit_now;
      s1_last <= last_now;
    end
  end

  assign colv[KS-1] = s1_pix;

  generate
    if (KS > 1) begin : g_lines
      logic [PIX_W-1:0] ram_rd [SLOTS];

      // one ram per slot; each row goes to the slot of its row number
      for (genvar j = 0; j < SLOTS; j++) begin : g_slot
        rwc_ram #(
          .WIDTH (PIX_W),
          .DEPTH (MAX_WIDTH)
        ) u_line (
          .clk     (clk),
          .wr_en   (in_acc && (slot == SW'(j))),
          .wr_addr (col),
          .wr_data (pix),
          .rd_en   (in_acc),
          .rd_addr (col),
          .rd_data (ram_rd[j])
        );
      end

      // window row r takes the line d rows above the current one
      for (genvar r = 0; r < KS - 1; r++) begin : g_tap
        localparam int D = KS - 1 - r;
        logic [SW:0]   sel_next;
        logic [SW-1:0] sel_q;
        logic          ok_q;

        always_comb begin
          if ({1'b0, slot} >= (SW+1)'(D)) begin
            sel_next = {1'b0, slot} - (SW+1)'(D);
          end else begin
            sel_next = {1'b0, slot} + (SW+1)'(SLOTS) - (SW+1)'(D);
          end
        end

        always_ff @(posedge clk) begin
          if (in_acc) begin
            sel_q <= sel_next[SW-1:0];
            ok_q  <= (row >= ROW_W'(D));
          end
        end

        // rows above the frame top load as zero
        assign colv[r] = ok_q ? ram_rd[sel_q] : '0;
      end
    end
  endgenerate

  // --------------------------------------------------------------------------
  // stage 2: window shift
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] window [KS][KS];
  logic             s2_valid;
  logic             s2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < KS; r++) begin
        for (int c = 0; c < KS; c++) begin
          window[r][c] <= '0;
        end
      end
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && s1_emit;
      if (s1_valid) begin
        for (int r = 0; r < KS; r++) begin
          for (int c = 0; c < KS - 1; c++) begin
            window[r][c] <= window[r][c+1];
          end
          window[r][KS-1] <= colv[r];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_last <= s1_last;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: products, one small multiplier per tap and channel
  // --------------------------------------------------------------------------
  logic [PW-1:0] prod [3][KS][KS];
  logic          s3_valid;
  logic          s3_last;

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < KS; r++) begin
        for (int c = 0; c < KS; c++) begin
          prod[ch][r][c] <= PW'(coef_row[r][c*COEF_BITS +: COEF_BITS])
                          * PW'(window[r][c][ch*8 +: 8]);
        end
      end
    end
    s3_last <= s2_last;
  end

  // --------------------------------------------------------------------------
  // stage 4: row sums
  // --------------------------------------------------------------------------
  logic [RSW-1:0] rsum_next [3][KS];
  logic [RSW-1:0] rsum [3][KS];
  logic           s4_valid;
  logic           s4_last;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < KS; r++) begin
        rsum_next[ch][r] = '0;
        for (int c = 0; c < KS; c++) begin
          rsum_next[ch][r] = rsum_next[ch][r] + RSW'(prod[ch][r][c]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rsum    <= rsum_next;
    s4_last <= s3_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  // --------------------------------------------------------------------------
  // final sum, drop the fraction, clamp to 8 bits
  // --------------------------------------------------------------------------
  logic [TSW-1:0] total [3];
  logic [QW-1:0]  quot [3];
  logic [7:0]     chan [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      total[ch] = '0;
      for (int r = 0; r < KS; r++) begin
        total[ch] = total[ch] + TSW'(rsum[ch][r]);
      end
      quot[ch] = total[ch][TSW-1:COEF_BITS];
      chan[ch] = (|quot[ch][QW-1:8]) ? 8'hFF : quot[ch][7:0];
    end
  end

  // --------------------------------------------------------------------------
  // output queue: parts the pipeline from out_stall
  // --------------------------------------------------------------------------
  pixel_out_t         fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   fifo_count;

  always_ff @(posedge clk) begin
    if (s4_valid) begin
      fifo_mem[wr_ptr] <= '{red_out:    chan[0],
                            green_out:  chan[1],
                            blue_out:   chan[2],
                            frame_last: s4_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (s4_valid) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (out_acc) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      fifo_count <= fifo_count + (FIFO_AW+1)'(s4_valid) - (FIFO_AW+1)'(out_acc);
    end
  end

  assign out_valid = (fifo_count != '0);
  assign out_item  = fifo_mem[rd_ptr];

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("result credit count above queue depth");

  a_queue_within_credit: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= pending)
    else $error("output queue holds more items than owed results");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    s4_valid |-> (fifo_count < (FIFO_AW+1)'(FIFO_DEPTH)) || out_acc)
    else $error("output queue written while full");

  a_credit_step: assert property (@(posedge clk) disable iff (rst)
    (in_acc && emit_now && !out_acc) |=> (pending == $past(pending) + (FIFO_AW+1)'(1)))
    else $error("result credit not taken for an item that gives a result");
`endif

endmodule
